// File: hdl/tpft_pkg.sv
// Shared types and constants for the TCP port forwarding table.
package tpft_pkg;

    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int TIDX_W = 2;
    localparam int TGT_SLOTS = 4;
    localparam int ENTRY_W = ADDR_W + PORT_W + TIDX_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_FWD_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_3 = 3'd5;

    typedef enum logic [1:0] {
        ACT_DROP = 2'd0,
        ACT_TO_CLIENT = 2'd1,
        ACT_TO_TARGET = 2'd2
    } action_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIDX_W-1:0] tidx;
    } client_t;

    typedef struct packed {
        logic              is_tcp;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dest_ip;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
        logic              syn_flag;
        logic              fin_flag;
        logic              rst_flag;
    } pkt_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] out_src_addr;
        logic [ADDR_W-1:0] out_dest_ip;
        logic [PORT_W-1:0] out_src_port;
        logic [PORT_W-1:0] out_dst_port;
        logic              table_full;
        logic              entry_removed;
    } result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_t;

endpackage

// File: hdl/tpft_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface tpft_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/tcp_port_forward_table_unit.sv
// Top level: TCP port forwarding connection table with client table in RAM.
// A drop without a scan passes the classify and output states; a scan reads and checks each
// stored client in turn, and a removal adds a read of the last entry and its move.
// One packet at a time, the next accepted in the cycle after the result is registered.
// A stalled result waits in the output register. Reset clears the client count,
// configuration registers and control state; the RAM is not.
module tcp_port_forward_table_unit #(
    parameter int MAX_CLIENTS = 64,
    parameter int NUM_TARGETS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    tpft_stream_if.sink   pkt_in,
    tpft_stream_if.source res_out,
    tpft_stream_if.sink   cfg
);

    localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
    localparam int NT_EFF = (NUM_TARGETS < tpft_pkg::TGT_SLOTS) ? NUM_TARGETS
                                                                : tpft_pkg::TGT_SLOTS;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLASS  = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_CHECK  = 7'b0001000,
        ST_RDLAST = 7'b0010000,
        ST_MOVE   = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [tpft_pkg::ADDR_W-1:0] fwd_addr_reg;
    logic [2:0]                  tgt_count_reg;
    logic [tpft_pkg::CFG_DATA_W-1:0] tgt_reg [tpft_pkg::TGT_SLOTS];

    tpft_pkg::client_t mem [MAX_CLIENTS];
    tpft_pkg::client_t rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    tpft_pkg::client_t mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] hit_reg, hit_next;

    tpft_pkg::pkt_t    pkt_reg, pkt_next;
    tpft_pkg::result_t work_reg, work_next;
    tpft_pkg::result_t res_reg, res_next;
    logic              res_valid_reg, res_valid_next;
    logic              from_tgt_reg, from_tgt_next;
    logic [1:0]        tsel_reg, tsel_next;

    logic [2:0]  live_n;
    logic        ft_hit;
    logic [1:0]  ft_idx;
    logic        pp_hit;
    logic [1:0]  pp_idx;
    logic        match;

    function automatic logic [tpft_pkg::ADDR_W-1:0] t_addr(
        input logic [tpft_pkg::CFG_DATA_W-1:0] e);
        return e[63:32];
    endfunction
    function automatic logic [tpft_pkg::PORT_W-1:0] t_pub(
        input logic [tpft_pkg::CFG_DATA_W-1:0] e);
        return e[31:16];
    endfunction
    function automatic logic [tpft_pkg::PORT_W-1:0] t_back(
        input logic [tpft_pkg::CFG_DATA_W-1:0] e);
        return e[15:0];
    endfunction

    assign cfg.ready = 1'b1;
    assign pkt_in.ready = (state_reg == ST_IDLE);
    assign res_out.valid = res_valid_reg;
    assign res_out.payload = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_addr_reg <= '0;
            tgt_count_reg <= '0;
            for (int i = 0; i < tpft_pkg::TGT_SLOTS; i++)
            begin
                tgt_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                tpft_pkg::REG_FWD_ADDR:  fwd_addr_reg <= cfg.payload.data[31:0];
                tpft_pkg::REG_TGT_COUNT: tgt_count_reg <= cfg.payload.data[2:0];
                tpft_pkg::REG_TGT_0:     tgt_reg[0] <= cfg.payload.data;
                tpft_pkg::REG_TGT_1:     tgt_reg[1] <= cfg.payload.data;
                tpft_pkg::REG_TGT_2:     tgt_reg[2] <= cfg.payload.data;
                tpft_pkg::REG_TGT_3:     tgt_reg[3] <= cfg.payload.data;
                default: ;
            endcase
        end
    end

    assign live_n = (tgt_count_reg > 3'(NT_EFF)) ? 3'(NT_EFF) : tgt_count_reg;

    always_comb
    begin
        ft_hit = 1'b0;
        ft_idx = '0;
        pp_hit = 1'b0;
        pp_idx = '0;
        for (int t = tpft_pkg::TGT_SLOTS - 1; t >= 0; t--)
        begin
            if (3'(t) < live_n)
            begin
                if (t_addr(tgt_reg[t]) == pkt_reg.src_addr
                    && t_back(tgt_reg[t]) == pkt_reg.src_port)
                begin
                    ft_hit = 1'b1;
                    ft_idx = 2'(t);
                end
                if (t_pub(tgt_reg[t]) == pkt_reg.dst_port)
                begin
                    pp_hit = 1'b1;
                    pp_idx = 2'(t);
                end
            end
        end
    end

    always_comb
    begin
        if (from_tgt_reg)
        begin
            match = t_addr(tgt_reg[rd_data_reg.tidx]) == pkt_reg.src_addr
                    && rd_data_reg.port == pkt_reg.dst_port;
        end
        else
        begin
            match = rd_data_reg.addr == pkt_reg.src_addr
                    && rd_data_reg.port == pkt_reg.src_port;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next = scan_reg;
        hit_next = hit_reg;
        pkt_next = pkt_reg;
        work_next = work_reg;
        res_next = res_reg;
        res_valid_next = res_valid_reg;
        from_tgt_next = from_tgt_reg;
        tsel_next = tsel_reg;
        mem_we = 1'b0;
        mem_waddr = IDX_W'(count_reg);
        mem_wdata = rd_data_reg;
        mem_re = 1'b0;
        mem_raddr = IDX_W'(scan_reg);

        if (res_valid_reg && res_out.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pkt_in.valid)
                begin
                    pkt_next = pkt_in.payload;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                work_next = '0;
                scan_next = '0;
                from_tgt_next = ft_hit;
                tsel_next = ft_hit ? ft_idx : pp_idx;
                if (!pkt_reg.is_tcp || (!ft_hit && !pp_hit))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (scan_reg < count_reg)
                begin
                    mem_re = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_OUT;
                    if (!from_tgt_reg && pkt_reg.syn_flag)
                    begin
                        if (count_reg >= CNT_W'(MAX_CLIENTS))
                        begin
                            work_next.table_full = 1'b1;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_wdata.addr = pkt_reg.src_addr;
                            mem_wdata.port = pkt_reg.src_port;
                            mem_wdata.tidx = tsel_reg;
                            count_next = count_reg + 1'b1;
                            work_next.action = tpft_pkg::ACT_TO_TARGET;
                            work_next.out_src_addr = fwd_addr_reg;
                            work_next.out_dest_ip = t_addr(tgt_reg[tsel_reg]);
                            work_next.out_src_port = pkt_reg.src_port;
                            work_next.out_dst_port = t_back(tgt_reg[tsel_reg]);
                        end
                    end
                end
            end
            ST_CHECK:
            begin
                if (match)
                begin
                    state_next = ST_OUT;
                    work_next.out_src_addr = fwd_addr_reg;
                    if (from_tgt_reg)
                    begin
                        work_next.action = tpft_pkg::ACT_TO_CLIENT;
                        work_next.out_dest_ip = rd_data_reg.addr;
                        work_next.out_src_port = t_pub(tgt_reg[tsel_reg]);
                        work_next.out_dst_port = pkt_reg.dst_port;
                    end
                    else
                    begin
                        work_next.action = tpft_pkg::ACT_TO_TARGET;
                        work_next.out_dest_ip = t_addr(tgt_reg[tsel_reg]);
                        work_next.out_src_port = pkt_reg.src_port;
                        work_next.out_dst_port = t_back(tgt_reg[rd_data_reg.tidx]);
                        if (pkt_reg.fin_flag || pkt_reg.rst_flag)
                        begin
                            work_next.entry_removed = 1'b1;
                            hit_next = IDX_W'(scan_reg);
                            state_next = ST_RDLAST;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_RDLAST:
            begin
                mem_re = 1'b1;
                mem_raddr = IDX_W'(count_reg - 1'b1);
                state_next = ST_MOVE;
            end
            ST_MOVE:
            begin
                mem_we = 1'b1;
                mem_waddr = hit_reg;
                mem_wdata = rd_data_reg;
                count_next = count_reg - 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!res_valid_reg || res_out.ready)
                begin
                    res_next = work_reg;
                    res_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        hit_reg <= hit_next;
        pkt_reg <= pkt_next;
        work_reg <= work_next;
        res_reg <= res_next;
        from_tgt_reg <= from_tgt_next;
        tsel_reg <= tsel_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_CLIENTS))
        else $error("client count exceeds table size");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |=> $stable(count_reg))
        else $error("client count changed while idle");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_out.ready |=> res_valid_reg && $stable(res_reg))
        else $error("pending result changed before transaction");

endmodule

// File: tb/tpft_tb_if.sv
`timescale 1ns / 1ps
// Stimulus row type for the testbench's directed table.
package tpft_tb_types;

    typedef struct {
        tpft_pkg::pkt_t    pkt;
        logic              has_exp;
        tpft_pkg::result_t exp;
    } stim_row_t;
endpackage

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TCP port forwarding connection table.
module tb;

    localparam int MAXC = 64;
    localparam int LAT = 2 * MAXC + 20;
    localparam int RAND_ITEMS = 234;
    localparam logic [2:0] REG_SPARE = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   failed = 1'b0;
    bit   hold_idle = 1'b0;

    tpft_stream_if #(.payload_t(tpft_pkg::pkt_t))    pkt_ch();
    tpft_stream_if #(.payload_t(tpft_pkg::result_t)) res_ch();
    tpft_stream_if #(.payload_t(tpft_pkg::cfg_t))    cfg_ch();

    tcp_port_forward_table_unit #(.MAX_CLIENTS(MAXC), .NUM_TARGETS(4)) DUT (
        .clk(clk), .rst_n(rst_n), .pkt_in(pkt_ch.sink), .res_out(res_ch.source),
        .cfg(cfg_ch.sink)
    );

    always #10 clk = ~clk;

    logic [31:0]         fwd_addr;
    logic [2:0]          tgt_count;
    logic [63:0]         tgt_entry [4];
    tpft_pkg::client_t   clients [MAXC];
    int                  n_clients;
    tpft_pkg::result_t   pending_results[$];

    function automatic tpft_pkg::result_t forward_decision(tpft_pkg::pkt_t p);
        tpft_pkg::result_t r;
        int nt;
        int t;
        int i;
        int hit;
        r = '0;
        nt = (tgt_count > 4) ? 4 : tgt_count;
        if (!p.is_tcp)
            return r;
        hit = -1;
        for (t = 0; t < nt; t++)
            if (hit < 0 && tgt_entry[t][63:32] == p.src_addr && tgt_entry[t][15:0] == p.src_port)
                hit = t;
        if (hit >= 0) begin
            for (i = 0; i < n_clients; i++)
                if (tgt_entry[clients[i].tidx][63:32] == p.src_addr
                        && clients[i].port == p.dst_port) begin
                    r.action = tpft_pkg::ACT_TO_CLIENT;
                    r.out_src_addr = fwd_addr;
                    r.out_dest_ip = clients[i].addr;
                    r.out_src_port = tgt_entry[hit][31:16];
                    r.out_dst_port = p.dst_port;
                    return r;
                end
            return r;
        end
        for (t = 0; t < nt; t++)
            if (hit < 0 && tgt_entry[t][31:16] == p.dst_port)
                hit = t;
        if (hit < 0)
            return r;
        for (i = 0; i < n_clients; i++)
            if (clients[i].addr == p.src_addr && clients[i].port == p.src_port) begin
                r.action = tpft_pkg::ACT_TO_TARGET;
                r.out_src_addr = fwd_addr;
                r.out_dest_ip = tgt_entry[hit][63:32];
                r.out_src_port = p.src_port;
                r.out_dst_port = tgt_entry[clients[i].tidx][15:0];
                if (p.rst_flag || p.fin_flag) begin
                    clients[i] = clients[n_clients - 1];
                    n_clients--;
                    r.entry_removed = 1'b1;
                end
                return r;
            end
        if (p.syn_flag) begin
            if (n_clients >= MAXC) begin
                r.table_full = 1'b1;
                return r;
            end
            clients[n_clients] = '{addr: p.src_addr, port: p.src_port, tidx: hit[1:0]};
            n_clients++;
            r.action = tpft_pkg::ACT_TO_TARGET;
            r.out_src_addr = fwd_addr;
            r.out_dest_ip = tgt_entry[hit][63:32];
            r.out_src_port = p.src_port;
            r.out_dst_port = tgt_entry[hit][15:0];
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !hold_idle && ($urandom_range(99) < 19);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: data};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx) inside
            tpft_pkg::REG_FWD_ADDR: fwd_addr = data[31:0];
            tpft_pkg::REG_TGT_COUNT: tgt_count = data[2:0];
            [tpft_pkg::REG_TGT_0:tpft_pkg::REG_TGT_3]:
                tgt_entry[2'(idx - tpft_pkg::REG_TGT_0)] = data;
            default: ;
        endcase
    endtask

    task automatic send_pkt(tpft_pkg::pkt_t p, logic has_exp, tpft_pkg::result_t exp);
        tpft_pkg::result_t r;
        while (idle_now()) begin
            pkt_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pkt_ch.valid <= 1'b1;
        pkt_ch.payload <= p;
        do
            @(posedge clk);
        while (!pkt_ch.ready);
        r = forward_decision(p);
        pending_results.push_back(has_exp ? exp : r);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        pkt_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (LAT) @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (rst_n)
            res_ch.ready <= !idle_now();
    end

    always @(posedge clk) begin
        tpft_pkg::result_t e;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_results.pop_front();
                if (res_ch.payload.action != e.action) begin
                    $error("action exp %0d got %0d", e.action, res_ch.payload.action);
                    failed = 1'b1;
                end
                if (res_ch.payload.out_src_addr != e.out_src_addr) begin
                    $error("out_src_addr exp %h got %h", e.out_src_addr,
                        res_ch.payload.out_src_addr);
                    failed = 1'b1;
                end
                if (res_ch.payload.out_dest_ip != e.out_dest_ip) begin
                    $error("out_dest_ip exp %h got %h", e.out_dest_ip,
                        res_ch.payload.out_dest_ip);
                    failed = 1'b1;
                end
                if (res_ch.payload.out_src_port != e.out_src_port) begin
                    $error("out_src_port exp %h got %h", e.out_src_port,
                        res_ch.payload.out_src_port);
                    failed = 1'b1;
                end
                if (res_ch.payload.out_dst_port != e.out_dst_port) begin
                    $error("out_dst_port exp %h got %h", e.out_dst_port,
                        res_ch.payload.out_dst_port);
                    failed = 1'b1;
                end
                if (res_ch.payload.table_full != e.table_full) begin
                    $error("table_full exp %0d got %0d", e.table_full,
                        res_ch.payload.table_full);
                    failed = 1'b1;
                end
                if (res_ch.payload.entry_removed != e.entry_removed) begin
                    $error("entry_removed exp %0d got %0d", e.entry_removed,
                        res_ch.payload.entry_removed);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic tpft_pkg::pkt_t mk(logic tcp, logic [31:0] sa, logic [31:0] da,
            logic [15:0] sp, logic [15:0] dp, logic s, logic f, logic r);
        tpft_pkg::pkt_t p;
        p = '{is_tcp: tcp, src_addr: sa, dest_ip: da, src_port: sp, dst_port: dp,
            syn_flag: s, fin_flag: f, rst_flag: r};
        return p;
    endfunction

    function automatic tpft_pkg::result_t res(logic [1:0] a, logic [31:0] sa, logic [31:0] da,
            logic [15:0] sp, logic [15:0] dp, logic tf, logic rm);
        tpft_pkg::result_t r;
        r = '{action: a, out_src_addr: sa, out_dest_ip: da, out_src_port: sp,
            out_dst_port: dp, table_full: tf, entry_removed: rm};
        return r;
    endfunction

    // random packet biased toward targets and known clients
    function automatic tpft_pkg::pkt_t rand_pkt();
        tpft_pkg::pkt_t p;
        int nt;
        int k;
        int sel;
        p.src_addr = $urandom;
        p.dest_ip = $urandom;
        p.src_port = 16'($urandom);
        p.dst_port = 16'($urandom);
        p.is_tcp = ($urandom_range(15) != 0);
        nt = (tgt_count > 4) ? 4 : ((tgt_count == 0) ? 1 : tgt_count);
        k = $urandom_range(nt - 1);
        sel = $urandom_range(9);
        p.syn_flag = $urandom_range(2) == 0;
        p.fin_flag = $urandom_range(5) == 0;
        p.rst_flag = $urandom_range(7) == 0;
        if (sel < 4) begin
            p.dst_port = tgt_entry[k][31:16];
            if (n_clients > 0 && $urandom_range(1)) begin
                p.src_addr = clients[$urandom_range(n_clients - 1)].addr;
                p.src_port = clients[$urandom_range(n_clients - 1)].port;
            end else begin
                p.src_addr = $urandom_range(7);
                p.src_port = 16'($urandom_range(7));
            end
        end else if (sel < 8) begin
            p.src_addr = tgt_entry[k][63:32];
            p.src_port = tgt_entry[k][15:0];
            if (n_clients > 0)
                p.dst_port = clients[$urandom_range(n_clients - 1)].port;
        end
        return p;
    endfunction

    tpft_tb_types::stim_row_t rows[$];

    initial begin
        tpft_pkg::pkt_t p;
        int ph;
        int i;
        pkt_ch.valid = 1'b0;
        pkt_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        res_ch.ready = 1'b0;
        fwd_addr = '0;
        tgt_count = '0;
        foreach (tgt_entry[k])
            tgt_entry[k] = '0;
        n_clients = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back('{mk(1, 1, 2, 3, 0, 1, 0, 0), 1'b1,
            res(tpft_pkg::ACT_DROP, 0, 0, 0, 0, 0, 0)});
        foreach (rows[k])
            send_pkt(rows[k].pkt, rows[k].has_exp, rows[k].exp);
        drain();
        rows.delete();

        write_reg(tpft_pkg::REG_FWD_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tpft_pkg::REG_TGT_COUNT, 64'd7);
        write_reg(tpft_pkg::REG_TGT_0, 64'h0A00_0001_0050_1F90);
        write_reg(tpft_pkg::REG_TGT_1, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(tpft_pkg::REG_TGT_2, 64'h0000_0000_0000_0000);
        write_reg(tpft_pkg::REG_TGT_3, 64'h0A00_0001_0050_0001);
        write_reg(REG_SPARE, 64'h1234);
        cfg_ch.valid <= 1'b0;

        rows.push_back('{mk(0, 5, 0, 9, 16'h50, 1, 0, 0), 1'b1,
            res(tpft_pkg::ACT_DROP, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(1, 5, 0, 9, 16'h51, 1, 0, 0), 1'b1,
            res(tpft_pkg::ACT_DROP, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(1, 5, 0, 9, 16'h50, 0, 0, 0), 1'b1,
            res(tpft_pkg::ACT_DROP, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(1, 5, 3, 9, 16'h50, 1, 0, 0), 1'b1,
            res(tpft_pkg::ACT_TO_TARGET, 32'hFFFF_FFFF, 32'h0A00_0001, 9, 16'h1F90, 0, 0)});
        rows.push_back('{mk(1, 32'h0A00_0001, 0, 16'h1F90, 9, 0, 0, 0), 1'b0, '0});
        rows.push_back('{mk(1, 32'h0A00_0001, 0, 16'h1F90, 8, 0, 0, 0), 1'b1,
            res(tpft_pkg::ACT_DROP, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(1, 32'hFFFF_FFFF, 1, 16'hFFFF, 16'hFFFF, 1, 0, 0), 1'b0, '0});
        rows.push_back('{mk(1, 0, 0, 0, 0, 1, 0, 0), 1'b0, '0});
        rows.push_back('{mk(1, 5, 0, 9, 16'hFFFF, 0, 1, 0), 1'b0, '0});
        rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
        rows.push_back('{mk(1, 32'hFFFF_FFFF, 0, 16'hFFFF, 16'h50, 1, 1, 1), 1'b0, '0});
        rows.push_back('{mk(1, 32'h0A00_0001, 0, 16'h0001, 16'hFFFF, 0, 0, 0), 1'b0, '0});
        foreach (rows[k])
            send_pkt(rows[k].pkt, rows[k].has_exp, rows[k].exp);
        drain();

        for (i = 0; i < MAXC + 2; i++) begin
            p = mk(1, 32'h0C00_0000 + 32'(i), $urandom, i[15:0], 16'h50, 1, 0, 0);
            send_pkt(p, 1'b0, '0);
        end
        drain();

        for (ph = 0; ph < 5; ph++) begin
            hold_idle = (ph == 2);
            write_reg(tpft_pkg::REG_FWD_ADDR, (ph == 4) ? 64'd0 : {32'd0, $urandom});
            write_reg(tpft_pkg::REG_TGT_COUNT, (ph == 3) ? 64'd0 : 64'($urandom_range(1, 5)));
            for (i = 0; i < 4; i++)
                write_reg(3'(tpft_pkg::REG_TGT_0 + 3'(i)),
                    {$urandom_range(3), ($urandom_range(3) == 0) ? 16'hFFFF :
                    16'($urandom_range(1, 4)), 16'($urandom_range(3))});
            cfg_ch.valid <= 1'b0;
            for (i = 0; i < RAND_ITEMS; i++)
                send_pkt(rand_pkt(), 1'b0, '0);
            drain();
        end
        hold_idle = 1'b0;
        drain();
        if (!failed && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: tcp_port_forward_table_unit.f
hdl/tpft_pkg.sv
hdl/tpft_stream_if.sv
hdl/tcp_port_forward_table_unit.sv
tb/tpft_tb_if.sv
tb/tb.sv
